FILE: rtl/led_pwm_pkg.sv
// Package for the LED strip PWM bit encoder: item types, register indexes and constants.
package led_pwm_pkg;

    // Data slots sent per LED; 24 color bits, the rest carry the zero-bit duty.
    localparam int BITS_PER_LED = 24;
    localparam int SLOT_CNT_W   = $clog2(BITS_PER_LED + 1);

    localparam int DUTY_W  = 16;
    localparam int LEVEL_W = 12;
    localparam int PCT_W   = 7;    // level / 33 stays below 128
    localparam int PROD_W  = 15;   // widened channel times percent stays below 2^15

    // Field masks of an RGB565 pixel.
    localparam logic [15:0] RED_MASK   = 16'hF800;
    localparam logic [15:0] GREEN_MASK = 16'h07E0;
    localparam logic [15:0] BLUE_MASK  = 16'h001F;

    // floor(x / 33) = (x * 3972) >> 17 for any 12-bit x.
    localparam int             PCT_SHIFT = 17;
    localparam logic [11:0]    PCT_RECIP = 12'd3972;
    // floor(x / 100) = (x * 20972) >> 21 for x below 2^15.
    localparam int             CH_SHIFT  = 21;
    localparam logic [14:0]    CH_RECIP  = 15'd20972;

    localparam logic [DUTY_W-1:0] HIGH_DUTY_RST = 16'd58;
    localparam logic [DUTY_W-1:0] LOW_DUTY_RST  = 16'd29;

    typedef enum logic [0:0] {
        CFG_HIGH_DUTY = 1'b0,
        CFG_LOW_DUTY  = 1'b1
    } cfg_index_t;

    typedef logic [BITS_PER_LED-1:0] led_word_t;

    typedef struct packed {
        logic [15:0]        pixel_rgb565;
        logic [LEVEL_W-1:0] level_mv;
        logic               last_pixel;
    } pixel_in_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              last;
    } slot_out_t;

endpackage

FILE: rtl/led_strip_pwm_bit_encoder.sv
// Top level of the LED strip PWM bit encoder: brightness scaling pipeline and slot serializer.
//
// Each accepted pixel item yields a zero reset slot, then BITS_PER_LED duty slots (green, red,
// blue, MSB first; high_duty for a one bit, low_duty for a zero bit), and one more zero slot
// when last_pixel is set; m_data.last marks the final slot of each item. The output slot
// register sends one slot per cycle when m_ready does not stall it, and in a steady stream
// slots of consecutive pixels follow with no gap. A pixel passes three registered stages
// (percent, channel products, divide-by-100 into the serializer), and its reset slot leaves
// the last of them when the output is free. Write high_duty and low_duty only while no item
// is in flight.
module led_strip_pwm_bit_encoder (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  led_pwm_pkg::pixel_in_t s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output led_pwm_pkg::slot_out_t m_data,
    input  logic                   cfg_wr_en,
    input  logic [0:0]             cfg_index,
    input  logic [15:0]            cfg_wdata
);
    import led_pwm_pkg::*;

    // Duty registers
    logic [DUTY_W-1:0] high_duty_reg;
    logic [DUTY_W-1:0] low_duty_reg;

    // Stage 0: input register
    logic               st0_valid_reg;
    logic [15:0]        st0_pixel_reg;
    logic [LEVEL_W-1:0] st0_level_reg;
    logic               st0_last_reg;

    // Stage 1: brightness percent
    logic               st1_valid_reg;
    logic [15:0]        st1_pixel_reg;
    logic [PCT_W-1:0]   st1_pct_reg;
    logic               st1_last_reg;

    // Stage 2: channel times percent
    logic               st2_valid_reg;
    logic [PROD_W-1:0]  st2_prod_r_reg;
    logic [PROD_W-1:0]  st2_prod_g_reg;
    logic [PROD_W-1:0]  st2_prod_b_reg;
    logic               st2_last_reg;

    // Serializer
    led_word_t             word_reg;
    logic [SLOT_CNT_W-1:0] cnt_reg;
    logic                  trail_reg;
    logic                  m_valid_reg;
    slot_out_t             m_data_reg;

    logic out_free;
    logic load_ok;
    logic st2_ready;
    logic st1_ready;
    logic st0_ready;

    logic [23:0]        pct_prod;
    logic [PCT_W-1:0]   pct_next;
    logic [7:0]         r_wide;
    logic [7:0]         g_wide;
    logic [7:0]         b_wide;
    logic [29:0]        div_r;
    logic [29:0]        div_g;
    logic [29:0]        div_b;
    logic [23:0]        grb;
    led_word_t          word_load;

    // Handshake chain: each stage moves when the next one is empty or moving.
    assign out_free  = !m_valid_reg || m_ready;
    assign load_ok   = out_free && (cnt_reg == '0) && !trail_reg;
    assign st2_ready = !st2_valid_reg || load_ok;
    assign st1_ready = !st1_valid_reg || st2_ready;
    assign st0_ready = !st0_valid_reg || st1_ready;
    assign s_ready   = st0_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Datapath
    assign pct_prod = 24'(st0_level_reg) * 24'(PCT_RECIP);
    assign pct_next = pct_prod[PCT_SHIFT+PCT_W-1:PCT_SHIFT];

    assign r_wide = {st1_pixel_reg[15:11], 3'b000};
    assign g_wide = {st1_pixel_reg[10:5], 2'b00};
    assign b_wide = {st1_pixel_reg[4:0], 3'b000};

    assign div_r = 30'(st2_prod_r_reg) * 30'(CH_RECIP);
    assign div_g = 30'(st2_prod_g_reg) * 30'(CH_RECIP);
    assign div_b = 30'(st2_prod_b_reg) * 30'(CH_RECIP);

    // Scaled channels wrap to their low 8 bits.
    assign grb       = {div_g[CH_SHIFT+7:CH_SHIFT], div_r[CH_SHIFT+7:CH_SHIFT],
                        div_b[CH_SHIFT+7:CH_SHIFT]};
    assign word_load = led_word_t'(grb) << (BITS_PER_LED - 24);

    // Configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_duty_reg <= HIGH_DUTY_RST;
            low_duty_reg  <= LOW_DUTY_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_HIGH_DUTY: high_duty_reg <= cfg_wdata;
                CFG_LOW_DUTY:  low_duty_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st0_valid_reg <= 1'b0;
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end else begin
            if (st0_ready) st0_valid_reg <= s_valid;
            if (st1_ready) st1_valid_reg <= st0_valid_reg;
            if (st2_ready) st2_valid_reg <= st1_valid_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge aclk) begin
        if (st0_ready && s_valid) begin
            st0_pixel_reg <= s_data.pixel_rgb565;
            st0_level_reg <= s_data.level_mv;
            st0_last_reg  <= s_data.last_pixel;
        end
        if (st1_ready && st0_valid_reg) begin
            st1_pixel_reg <= st0_pixel_reg & (RED_MASK | GREEN_MASK | BLUE_MASK);
            st1_pct_reg   <= pct_next;
            st1_last_reg  <= st0_last_reg;
        end
        if (st2_ready && st1_valid_reg) begin
            st2_prod_r_reg <= PROD_W'(r_wide) * PROD_W'(st1_pct_reg);
            st2_prod_g_reg <= PROD_W'(g_wide) * PROD_W'(st1_pct_reg);
            st2_prod_b_reg <= PROD_W'(b_wide) * PROD_W'(st1_pct_reg);
            st2_last_reg   <= st1_last_reg;
        end
    end

    // Serializer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            trail_reg   <= 1'b0;
        end else if (out_free) begin
            if (cnt_reg != '0) begin
                m_valid_reg <= 1'b1;
                cnt_reg     <= cnt_reg - SLOT_CNT_W'(1);
            end else if (trail_reg) begin
                m_valid_reg <= 1'b1;
                trail_reg   <= 1'b0;
            end else if (st2_valid_reg) begin
                m_valid_reg <= 1'b1;
                cnt_reg     <= SLOT_CNT_W'(BITS_PER_LED);
                trail_reg   <= st2_last_reg;
            end else begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Serializer payload
    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (cnt_reg != '0) begin
                m_data_reg.duty <= word_reg[BITS_PER_LED-1] ? high_duty_reg : low_duty_reg;
                m_data_reg.last <= (cnt_reg == SLOT_CNT_W'(1)) && !trail_reg;
                word_reg        <= word_reg << 1;
            end else if (trail_reg) begin
                m_data_reg.duty <= '0;
                m_data_reg.last <= 1'b1;
            end else if (st2_valid_reg) begin
                // reset slot ahead of the pixel's data slots
                m_data_reg.duty <= '0;
                m_data_reg.last <= 1'b0;
                word_reg        <= word_load;
            end
        end
    end

    // Assertions
    a_cnt_implies_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0) |-> m_valid_reg)
        else $error("data slots pending with no slot on the output");

    a_trail_implies_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        trail_reg |-> m_valid_reg)
        else $error("trailing slot pending with no slot on the output");

    a_last_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.last) |-> ((cnt_reg == '0) && !trail_reg))
        else $error("last slot shown while slots of the item remain");

    a_load_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_ok && st2_valid_reg) |=> (cnt_reg == SLOT_CNT_W'(BITS_PER_LED)))
        else $error("slot count wrong after loading a pixel");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= SLOT_CNT_W'(BITS_PER_LED))
        else $error("slot count out of range");

endmodule

FILE: tb/sv/led_strip_pwm_bit_encoder_check.sv
`timescale 1ns / 100ps
// Checker for the LED strip PWM bit encoder: predicts the duty slots of each pixel and compares.
module led_strip_pwm_bit_encoder_check (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  led_pwm_pkg::pixel_in_t s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  led_pwm_pkg::slot_out_t m_data,
    input  logic                   cfg_wr_en,
    input  logic [0:0]             cfg_index,
    input  logic [15:0]            cfg_wdata,
    output int                     fail_count,
    output int                     pending
);
    import led_pwm_pkg::*;

    logic [DUTY_W-1:0] one_duty  = HIGH_DUTY_RST;
    logic [DUTY_W-1:0] zero_duty = LOW_DUTY_RST;
    slot_out_t         slots_due[$];
    int                slots_seen = 0;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    // Widened channel times percent, divided by 100, wrapped to 8 bits.
    function automatic logic [7:0] dimmed_channel(input int unsigned wide, input int unsigned pct);
        int unsigned prod;
        prod = (wide * pct) / 100;
        return prod[7:0];
    endfunction

    function automatic void queue_pixel_slots(input pixel_in_t px);
        int unsigned pct;
        logic [7:0]  red, green, blue;
        led_word_t   grb;
        slot_out_t   slot;
        pct   = px.level_mv / 33;
        red   = dimmed_channel(((px.pixel_rgb565 & RED_MASK) >> 11) * 8, pct);
        green = dimmed_channel(((px.pixel_rgb565 & GREEN_MASK) >> 5) * 4, pct);
        blue  = dimmed_channel((px.pixel_rgb565 & BLUE_MASK) * 8, pct);
        // color bits sit at the top; any extra slots below them carry zero bits
        grb = led_word_t'({green, red, blue}) << (BITS_PER_LED - 24);
        slot = '0;
        slots_due.push_back(slot);
        for (int i = BITS_PER_LED - 1; i >= 0; i--) begin
            slot.duty = grb[i] ? one_duty : zero_duty;
            slot.last = 1'b0;
            slots_due.push_back(slot);
        end
        if (px.last_pixel) begin
            slot = '0;
            slots_due.push_back(slot);
        end
        slots_due[$].last = 1'b1;
    endfunction

    task automatic note_mismatch(input string what, input int want_v, input int got_v);
        fail_count++;
        if (fail_count <= 10) begin
            $display("slot %0d: %s expected %0d, got %0d", slots_seen, what, want_v, got_v);
        end
    endtask

    always @(posedge aclk) begin
        slot_out_t want;
        if (!aresetn) begin
            one_duty  = HIGH_DUTY_RST;
            zero_duty = LOW_DUTY_RST;
            slots_due.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_HIGH_DUTY) begin
                    one_duty = cfg_wdata;
                end else begin
                    zero_duty = cfg_wdata;
                end
            end
            if (m_valid && m_ready) begin
                if (slots_due.size() == 0) begin
                    note_mismatch("unexpected slot, duty", -1, int'(m_data.duty));
                end else begin
                    want = slots_due.pop_front();
                    if (m_data.duty !== want.duty) begin
                        note_mismatch("duty", int'(want.duty), int'(m_data.duty));
                    end
                    if (m_data.last !== want.last) begin
                        note_mismatch("last", int'(want.last), int'(m_data.last));
                    end
                end
                slots_seen++;
            end
            if (s_valid && s_ready) begin
                queue_pixel_slots(s_data);
            end
        end
        pending = slots_due.size();
    end

endmodule

FILE: tb/sv/led_strip_pwm_bit_encoder_test.sv
`timescale 1ns / 100ps
// Testbench top for the LED strip PWM bit encoder: clock, reset, pixel stimulus and verdict.
module led_strip_pwm_bit_encoder_test;
    import led_pwm_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 12;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    pixel_in_t   s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    slot_out_t   m_data;
    logic        cfg_wr_en = 1'b0;
    logic [0:0]  cfg_index = CFG_HIGH_DUTY;
    logic [15:0] cfg_wdata = '0;

    int idle_pct    = 0;
    int stall_pct   = 0;
    int cycle_count = 0;
    int fail_count;
    int pending;

    led_strip_pwm_bit_encoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    led_strip_pwm_bit_encoder_check i_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[led_strip_pwm_bit_encoder] ERROR");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_pixel(input logic [15:0] rgb, input logic [11:0] level, input logic fin);
        pixel_in_t px;
        px.pixel_rgb565 = rgb;
        px.level_mv     = level;
        px.last_pixel   = fin;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_duties(input logic [15:0] one_val, input logic [15:0] zero_val);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_HIGH_DUTY;
        cfg_wdata <= one_val;
        @(negedge aclk);
        cfg_index <= CFG_LOW_DUTY;
        cfg_wdata <= zero_val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random(input int count, input int idle, input int stall);
        logic [11:0] level;
        idle_pct  = idle;
        stall_pct = stall;
        for (int n = 0; n < count; n++) begin
            // a quarter of the items sit at high brightness where channels wrap
            if ($urandom_range(3) == 0) begin
                level = 12'($urandom_range(4095, 3300));
            end else begin
                level = 12'($urandom_range(4095, 0));
            end
            send_pixel(16'($urandom_range(65535, 0)), level, $urandom_range(3) == 0);
        end
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed items at reset duties
        send_pixel(16'h0000, 12'd0, 1'b0);
        send_pixel(16'hFFFF, 12'd4095, 1'b0);
        send_pixel(16'hFFFF, 12'd3300, 1'b1);
        send_pixel(16'hFFFF, 12'd3299, 1'b0);
        send_pixel(16'hF800, 12'd3300, 1'b0);
        send_pixel(16'h07E0, 12'd3300, 1'b0);
        send_pixel(16'h001F, 12'd3300, 1'b1);
        send_pixel(16'hFFFF, 12'd32, 1'b0);
        send_pixel(16'hFFFF, 12'd33, 1'b0);
        send_pixel(16'hAAAA, 12'hAAA, 1'b0);
        send_pixel(16'h5555, 12'h555, 1'b1);
        send_pixel(16'hFFFF, 12'd4094, 1'b0);
        send_pixel(16'h8410, 12'd2000, 1'b0);
        send_pixel(16'h0821, 12'd4095, 1'b1);
        send_pixel(16'hF81F, 12'd3960, 1'b1);
        wait_drained();

        write_duties(16'hFFFF, 16'h0000);
        run_random(24, 0, 0);
        wait_drained();

        write_duties(16'h0000, 16'hFFFF);
        run_random(12, 57, 0);
        // sender holds off until the encoder has emptied
        wait_drained();
        run_random(12, 57, 0);
        wait_drained();

        write_duties(16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)));
        run_random(24, 0, 57);
        wait_drained();

        write_duties(HIGH_DUTY_RST, LOW_DUTY_RST);
        run_random(24, 16, 16);
        wait_drained();

        if (fail_count == 0) begin
            $display("[led_strip_pwm_bit_encoder] OK");
        end else begin
            $display("[led_strip_pwm_bit_encoder] ERROR");
        end
        $finish;
    end

endmodule
